// ===== design/rfre_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package rfre_pkg;

	localparam int MAG_W  = 33;  // |robot - beacon| per axis
	localparam int SUM_W  = 66;  // sum of three squares
	localparam int ROOT_W = 34;  // floor(sqrt(sum))
	localparam int QUO_W  = 31;  // unit vector magnitude, up to 2^30
	localparam int CHI_W  = 63;

	// geometry after the difference stage
	typedef struct packed {
		logic [2:0]              neg;
		logic [2:0][MAG_W-1:0]   mag;
		logic signed [31:0]      bias;
		logic signed [31:0]      meas;
		logic [30:0]             w;
	} geo_t;

	// after the range / residual stage
	typedef struct packed {
		logic [2:0]              neg;
		logic [2:0][MAG_W-1:0]   mag;
		logic [ROOT_W-1:0]       d;
		logic signed [31:0]      pred;
		logic signed [31:0]      res;
		logic [31:0]             rmag;
		logic [30:0]             w;
		logic                    sat;
		logic                    zero;
	} mid_t;

	// result fields that ride along the divider
	typedef struct packed {
		logic signed [31:0]      pred;
		logic signed [31:0]      res;
		logic [CHI_W-1:0]        chi;
		logic                    sat;
		logic                    zero;
	} tag_t;

	typedef struct packed {
		logic [2:0]              neg;
		logic [2:0][MAG_W-1:0]   mag;
		logic [ROOT_W-1:0]       d;
		tag_t                    tag;
	} dvin_t;

endpackage
`default_nettype wire

// ===== design/range_factor_residual_eval.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Range factor evaluator: robot vs. biased beacon, Q16.16 fixed point.
//
// Input: a beat is taken on the rising edge where start is high and busy
// is low. busy is held low, so a new factor can be issued every cycle.
// Output: done is high for one cycle with the result fields; the receiver
// cannot hold it off, and none is needed since the pipe never backs up.
//
// Pipeline stages, from the accepting edge to the done register:
//   3  difference, squares, sum of squares
//   34 square root, one root bit per stage
//   1  predicted range and residual with clipping
//   3  chi-square: residual squared, times weight (split), shift + clip
//   31 unit vector divide, one quotient bit per stage, three lanes
//   1  sign and zero-distance fix-up, output register
// Throughput: one beat per cycle, set by the bit-per-stage root and divide.
// Reset clears every valid bit; in-flight beats are dropped and done stays
// low until new beats reach the end.
// zero_distance forces the unit vector to zero.
module range_factor_residual_eval #(
	parameter int FRAC_BITS = 16
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 start,
	output logic                busy,
	input  wire signed [31:0]   robot_x,
	input  wire signed [31:0]   robot_y,
	input  wire signed [31:0]   robot_z,
	input  wire signed [31:0]   beacon_x,
	input  wire signed [31:0]   beacon_y,
	input  wire signed [31:0]   beacon_z,
	input  wire signed [31:0]   range_bias,
	input  wire signed [31:0]   measured_range,
	input  wire [30:0]          weight,
	output logic                done,
	output logic signed [31:0]  predicted_range,
	output logic signed [31:0]  residual,
	output logic [62:0]         chi_square,
	output logic signed [31:0]  grad_x,
	output logic signed [31:0]  grad_y,
	output logic signed [31:0]  grad_z,
	output logic                zero_distance,
	output logic                saturated
);
	import rfre_pkg::*;

	logic               fr_valid;
	logic [SUM_W-1:0]   fr_sum;
	geo_t               fr_geo;
	logic               sq_valid;
	logic [ROOT_W-1:0]  sq_root;
	geo_t               sq_geo;
	logic               v_s1;
	mid_t               mid_s1;
	logic               ch_valid;
	dvin_t              ch_dv;
	logic               dv_valid;
	logic [2:0][QUO_W-1:0] dv_quo;
	dvin_t              dv_out;

	// range and residual, exact then clipped
	logic signed [34:0] pred_w;
	logic signed [35:0] res_w;
	logic               pred_ovf, res_ovf;
	logic signed [31:0] pred_c, res_c;
	logic [2:0][31:0]   grad_w;

	assign busy = 1'b0;

	rfre_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (start & ~busy),
		.robot_x        (robot_x),
		.robot_y        (robot_y),
		.robot_z        (robot_z),
		.beacon_x       (beacon_x),
		.beacon_y       (beacon_y),
		.beacon_z       (beacon_z),
		.range_bias     (range_bias),
		.measured_range (measured_range),
		.weight         (weight),
		.out_valid      (fr_valid),
		.out_sum        (fr_sum),
		.out_geo        (fr_geo)
	);

	rfre_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fr_valid),
		.in_sum    (fr_sum),
		.in_geo    (fr_geo),
		.out_valid (sq_valid),
		.out_root  (sq_root),
		.out_geo   (sq_geo)
	);

	always_comb begin
		pred_w   = $signed({1'b0, sq_root}) + 35'(sq_geo.bias);
		res_w    = 36'(sq_geo.meas) - 36'(pred_w);
		pred_ovf = (pred_w[34:31] != {4{pred_w[34]}});
		res_ovf  = (res_w[35:31] != {5{res_w[35]}});
		pred_c   = pred_ovf ? (pred_w[34] ? 32'sh8000_0000 : 32'sh7fff_ffff)
			: pred_w[31:0];
		res_c    = res_ovf ? (res_w[35] ? 32'sh8000_0000 : 32'sh7fff_ffff)
			: res_w[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else
			v_s1 <= sq_valid;
	end

	always_ff @(posedge clk) begin
		mid_s1.neg  <= sq_geo.neg;
		mid_s1.mag  <= sq_geo.mag;
		mid_s1.d    <= sq_root;
		mid_s1.pred <= pred_c;
		mid_s1.res  <= res_c;
		mid_s1.rmag <= res_c[31] ? (~res_c + 1'b1) : res_c;
		mid_s1.w    <= sq_geo.w;
		mid_s1.sat  <= pred_ovf | res_ovf;
		mid_s1.zero <= (sq_root == '0);
	end

	rfre_chi #(
		.FRAC_BITS (FRAC_BITS)
	) u_chi (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s1),
		.in_mid    (mid_s1),
		.out_valid (ch_valid),
		.out_dv    (ch_dv)
	);

	rfre_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (ch_valid),
		.in_dv     (ch_dv),
		.out_valid (dv_valid),
		.out_quo   (dv_quo),
		.out_dv    (dv_out)
	);

	// sign back on; a zero distance leaves the divide meaningless
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (dv_out.tag.zero)
				grad_w[i] = '0;
			else if (dv_out.neg[i])
				grad_w[i] = ~{1'b0, dv_quo[i]} + 1'b1;
			else
				grad_w[i] = {1'b0, dv_quo[i]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done <= 1'b0;
		else
			done <= dv_valid;
	end

	always_ff @(posedge clk) begin
		predicted_range <= dv_out.tag.pred;
		residual        <= dv_out.tag.res;
		chi_square      <= dv_out.tag.chi;
		grad_x          <= grad_w[0];
		grad_y          <= grad_w[1];
		grad_z          <= grad_w[2];
		zero_distance   <= dv_out.tag.zero;
		saturated       <= dv_out.tag.sat;
	end

	a_zero_grad : assert property (@(posedge clk) disable iff (!arst_n)
		done && zero_distance |-> grad_x == 0 && grad_y == 0 && grad_z == 0)
		else $error("unit vector not zero at zero distance");

	a_grad_range : assert property (@(posedge clk) disable iff (!arst_n)
		done |-> grad_x <= 32'sh4000_0000 && grad_x >= -32'sh4000_0000
			&& grad_y <= 32'sh4000_0000 && grad_y >= -32'sh4000_0000
			&& grad_z <= 32'sh4000_0000 && grad_z >= -32'sh4000_0000)
		else $error("unit vector component beyond one");

	a_chi_zero : assert property (@(posedge clk) disable iff (!arst_n)
		done && residual == 0 |-> chi_square == 0)
		else $error("chi-square nonzero with zero residual");

endmodule
`default_nettype wire

// ===== design/rfre_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module rfre_front (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	input  wire signed [31:0]   robot_x,
	input  wire signed [31:0]   robot_y,
	input  wire signed [31:0]   robot_z,
	input  wire signed [31:0]   beacon_x,
	input  wire signed [31:0]   beacon_y,
	input  wire signed [31:0]   beacon_z,
	input  wire signed [31:0]   range_bias,
	input  wire signed [31:0]   measured_range,
	input  wire [30:0]          weight,
	output logic                out_valid,
	output logic [rfre_pkg::SUM_W-1:0] out_sum,
	output rfre_pkg::geo_t      out_geo
);
	import rfre_pkg::*;

	logic signed [2:0][MAG_W-1:0] diff;
	geo_t                         geo_in;
	logic                         v_s1, v_s2;
	geo_t                         geo_s1, geo_s2;
	logic [2:0][2*MAG_W-1:0]      sq_s2;

	always_comb begin
		diff[0] = {robot_x[31], robot_x} - {beacon_x[31], beacon_x};
		diff[1] = {robot_y[31], robot_y} - {beacon_y[31], beacon_y};
		diff[2] = {robot_z[31], robot_z} - {beacon_z[31], beacon_z};
		for (int i = 0; i < 3; i++) begin
			geo_in.neg[i] = diff[i][MAG_W-1];
			geo_in.mag[i] = diff[i][MAG_W-1] ? (~diff[i] + 1'b1) : diff[i];
		end
		geo_in.bias = range_bias;
		geo_in.meas = measured_range;
		geo_in.w    = weight;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			v_s1      <= in_valid;
			v_s2      <= v_s1;
			out_valid <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		geo_s1 <= geo_in;
		geo_s2 <= geo_s1;
		for (int i = 0; i < 3; i++)
			sq_s2[i] <= geo_s1.mag[i] * geo_s1.mag[i];
		out_geo <= geo_s2;
		out_sum <= {1'b0, sq_s2[0][SUM_W-2:0]} + {1'b0, sq_s2[1][SUM_W-2:0]}
			+ {1'b0, sq_s2[2][SUM_W-2:0]};
	end

endmodule
`default_nettype wire

// ===== design/rfre_sqrt.sv =====
`timescale 1ns / 1ps
`default_nettype none
module rfre_sqrt (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          in_valid,
	input  wire [rfre_pkg::SUM_W-1:0]    in_sum,
	input  rfre_pkg::geo_t               in_geo,
	output logic                         out_valid,
	output logic [rfre_pkg::ROOT_W-1:0]  out_root,
	output rfre_pkg::geo_t               out_geo
);
	import rfre_pkg::*;

	localparam int TW = 2 * ROOT_W;

	// one root bit per stage, msb first
	logic              v_s    [ROOT_W];
	logic [SUM_W-1:0]  rem_s  [ROOT_W];
	logic [ROOT_W-1:0] root_s [ROOT_W];
	geo_t              geo_s  [ROOT_W];

	for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
		localparam int B = ROOT_W - 1 - k;
		logic              v_p;
		logic [SUM_W-1:0]  rem_p;
		logic [ROOT_W-1:0] root_p;
		geo_t              geo_p;
		logic [TW-1:0]     trial;
		logic [TW-1:0]     rem_x;
		logic              take;

		if (k == 0) begin : g_first
			assign v_p    = in_valid;
			assign rem_p  = in_sum;
			assign root_p = '0;
			assign geo_p  = in_geo;
		end else begin : g_next
			assign v_p    = v_s[k-1];
			assign rem_p  = rem_s[k-1];
			assign root_p = root_s[k-1];
			assign geo_p  = geo_s[k-1];
		end

		// (r + 2^B)^2 - r^2 = r*2^(B+1) + 2^(2B)
		assign trial = ({{(TW-ROOT_W){1'b0}}, root_p} << (B + 1))
			| ({{(TW-1){1'b0}}, 1'b1} << (2 * B));
		assign rem_x = {{(TW-SUM_W){1'b0}}, rem_p};
		assign take  = rem_x >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				v_s[k] <= 1'b0;
			else
				v_s[k] <= v_p;
		end

		always_ff @(posedge clk) begin
			geo_s[k] <= geo_p;
			if (take) begin
				rem_s[k]  <= SUM_W'(rem_x - trial);
				root_s[k] <= root_p | (ROOT_W'(1) << B);
			end else begin
				rem_s[k]  <= rem_p;
				root_s[k] <= root_p;
			end
		end
	end

	assign out_valid = v_s[ROOT_W-1];
	assign out_root  = root_s[ROOT_W-1];
	assign out_geo   = geo_s[ROOT_W-1];

endmodule
`default_nettype wire

// ===== design/rfre_chi.sv =====
`timescale 1ns / 1ps
`default_nettype none
module rfre_chi #(
	parameter int FRAC_BITS = 16
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                in_valid,
	input  rfre_pkg::mid_t     in_mid,
	output logic               out_valid,
	output rfre_pkg::dvin_t    out_dv
);
	import rfre_pkg::*;

	localparam int PW = 95;

	logic         v_s1, v_s2;
	mid_t         mid_s1, mid_s2;
	logic [63:0]  rsq_s1;
	logic [62:0]  plo_s2, phi_s2;
	logic [PW-1:0] prod;
	logic          ovf;

	assign prod = {{(PW-63){1'b0}}, plo_s2} + ({{(PW-63){1'b0}}, phi_s2} << 32);
	assign ovf  = |(prod >> (CHI_W + FRAC_BITS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			v_s1      <= in_valid;
			v_s2      <= v_s1;
			out_valid <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		mid_s1 <= in_mid;
		rsq_s1 <= in_mid.rmag * in_mid.rmag;
		mid_s2 <= mid_s1;
		plo_s2 <= rsq_s1[31:0] * mid_s1.w;
		phi_s2 <= rsq_s1[63:32] * mid_s1.w;
		out_dv.neg      <= mid_s2.neg;
		out_dv.mag      <= mid_s2.mag;
		out_dv.d        <= mid_s2.d;
		out_dv.tag.pred <= mid_s2.pred;
		out_dv.tag.res  <= mid_s2.res;
		out_dv.tag.zero <= mid_s2.zero;
		out_dv.tag.sat  <= mid_s2.sat | ovf;
		out_dv.tag.chi  <= ovf ? {CHI_W{1'b1}} : prod[FRAC_BITS +: CHI_W];
	end

endmodule
`default_nettype wire

// ===== design/rfre_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
module rfre_div (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   in_valid,
	input  rfre_pkg::dvin_t       in_dv,
	output logic                  out_valid,
	output logic [2:0][rfre_pkg::QUO_W-1:0] out_quo,
	output rfre_pkg::dvin_t       out_dv
);
	import rfre_pkg::*;

	localparam int RW = ROOT_W + 1;

	// restoring divide, three lanes, one quotient bit per stage
	logic                    v_s   [QUO_W];
	logic [2:0][RW-1:0]      rem_s [QUO_W];
	logic [2:0][QUO_W-1:0]   quo_s [QUO_W];
	dvin_t                   dv_s  [QUO_W];

	for (genvar k = 0; k < QUO_W; k++) begin : g_stage
		logic                  v_p;
		dvin_t                 dv_p;
		logic [2:0][RW-1:0]    x;
		logic [2:0][QUO_W-1:0] q_p;
		logic [2:0]            ge;

		if (k == 0) begin : g_first
			assign v_p  = in_valid;
			assign dv_p = in_dv;
			for (genvar l = 0; l < 3; l++) begin : g_l
				assign x[l]   = {{(RW-MAG_W){1'b0}}, in_dv.mag[l]};
				assign q_p[l] = '0;
			end
		end else begin : g_next
			assign v_p  = v_s[k-1];
			assign dv_p = dv_s[k-1];
			for (genvar l = 0; l < 3; l++) begin : g_l
				assign x[l]   = {rem_s[k-1][l][RW-2:0], 1'b0};
				assign q_p[l] = quo_s[k-1][l];
			end
		end

		for (genvar l = 0; l < 3; l++) begin : g_cmp
			assign ge[l] = x[l] >= {1'b0, dv_p.d};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				v_s[k] <= 1'b0;
			else
				v_s[k] <= v_p;
		end

		always_ff @(posedge clk) begin
			dv_s[k] <= dv_p;
			for (int l = 0; l < 3; l++) begin
				rem_s[k][l] <= ge[l] ? (x[l] - {1'b0, dv_p.d}) : x[l];
				quo_s[k][l] <= {q_p[l][QUO_W-2:0], ge[l]};
			end
		end
	end

	assign out_valid = v_s[QUO_W-1];
	assign out_quo   = quo_s[QUO_W-1];
	assign out_dv    = dv_s[QUO_W-1];

endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench for range_factor_residual_eval.
//
// Each factor beat is driven on the rising edge and is taken when start is
// high and busy is low. At that edge the local predictor works out the
// expected result, which goes on a queue. The checker compares every done
// cycle field by field with the head of that queue. Directed factors come
// first: coincident points, single-axis unit vectors, the corners of the
// coordinate range, and clipped range, residual and chi-square. Random
// factors follow: mostly nearby geometry, with some full-range noise.
module tb_top;

	localparam int FRAC       = 16;
	localparam int GRAD_SHIFT = 30;
	localparam int LATENCY    = 73;
	localparam int STALL_MAX  = 2000;  // cycles with no beat either way
	localparam longint S32_MAX = 64'sd2147483647;
	localparam longint S32_MIN = -64'sd2147483648;
	localparam logic [62:0] CHI_MAX = {63{1'b1}};

	typedef struct packed {
		logic signed [31:0] rx, ry, rz;
		logic signed [31:0] bx, by, bz;
		logic signed [31:0] bias;
		logic signed [31:0] meas;
		logic [30:0]        w;
	} factor_t;

	localparam int FACTOR_W = $bits(factor_t);

	typedef struct packed {
		logic signed [31:0] pred;
		logic signed [31:0] res;
		logic [62:0]        chi;
		logic signed [31:0] gx, gy, gz;
		logic               zero;
		logic               sat;
	} factor_eval_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic signed [31:0] robot_x = '0, robot_y = '0, robot_z = '0;
	logic signed [31:0] beacon_x = '0, beacon_y = '0, beacon_z = '0;
	logic signed [31:0] range_bias = '0, measured_range = '0;
	logic [30:0] weight = '0;
	logic done;
	logic signed [31:0] predicted_range, residual, grad_x, grad_y, grad_z;
	logic [62:0] chi_square;
	logic zero_distance, saturated;

	factor_eval_t pending_evals[$];
	int mismatches = 0;
	int idle_cycles = 0;
	bit gaps_on = 1'b1;

	always #6 clk = ~clk;

	range_factor_residual_eval uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.robot_x(robot_x), .robot_y(robot_y), .robot_z(robot_z),
		.beacon_x(beacon_x), .beacon_y(beacon_y), .beacon_z(beacon_z),
		.range_bias(range_bias), .measured_range(measured_range), .weight(weight),
		.done(done), .predicted_range(predicted_range), .residual(residual),
		.chi_square(chi_square), .grad_x(grad_x), .grad_y(grad_y), .grad_z(grad_z),
		.zero_distance(zero_distance), .saturated(saturated)
	);

	function automatic longint clip32(longint v, inout bit sat);
		if (v > S32_MAX) begin
			sat = 1'b1;
			return S32_MAX;
		end
		if (v < S32_MIN) begin
			sat = 1'b1;
			return S32_MIN;
		end
		return v;
	endfunction

	// unit vector component, truncated toward zero; zero when d is zero
	function automatic logic [31:0] unit_comp(longint diff, logic [33:0] d);
		logic [63:0] mag;
		logic [63:0] q;
		mag = (diff < 0) ? 64'(-diff) : 64'(diff);
		if (d == '0)
			return '0;
		q = (mag << GRAD_SHIFT) / {30'b0, d};
		return (diff < 0) ? 32'(-q) : 32'(q);
	endfunction

	function automatic factor_eval_t eval_range_factor(factor_t f);
		longint dx, dy, dz, pred, res;
		logic [67:0] ax, ay, az, sum, sq;
		logic [33:0] root, trial;
		logic [31:0] rmag;
		logic [127:0] prod, chi;
		bit sat;
		factor_eval_t r;
		sat = 1'b0;
		dx = longint'(f.rx) - longint'(f.bx);
		dy = longint'(f.ry) - longint'(f.by);
		dz = longint'(f.rz) - longint'(f.bz);
		ax = (dx < 0) ? 68'(-dx) : 68'(dx);
		ay = (dy < 0) ? 68'(-dy) : 68'(dy);
		az = (dz < 0) ? 68'(-dz) : 68'(dz);
		sum = ax * ax + ay * ay + az * az;
		// floor square root, one bit at a time from the top
		root = '0;
		for (int b = 33; b >= 0; b--) begin
			trial = root | (34'd1 << b);
			sq = {34'b0, trial} * {34'b0, trial};
			if (sq <= sum)
				root = trial;
		end
		pred = longint'({30'b0, root}) + longint'(f.bias);
		res = clip32(longint'(f.meas) - pred, sat);
		pred = clip32(pred, sat);
		rmag = (res < 0) ? 32'(-res) : 32'(res);
		prod = {96'b0, rmag} * {96'b0, rmag} * {97'b0, f.w};
		chi = prod >> FRAC;
		if (chi > {65'b0, CHI_MAX}) begin
			chi = {65'b0, CHI_MAX};
			sat = 1'b1;
		end
		r.pred = 32'(pred);
		r.res = 32'(res);
		r.chi = chi[62:0];
		r.gx = unit_comp(dx, root);
		r.gy = unit_comp(dy, root);
		r.gz = unit_comp(dz, root);
		r.zero = (root == '0);
		r.sat = sat;
		return r;
	endfunction

	task automatic report_mismatch(string field, logic [62:0] got, logic [62:0] want);
		$display("mismatch %s: got %h want %h at %0t", field, got, want, $realtime);
		mismatches++;
	endtask

	// result checker: one beat per done cycle
	always @(posedge clk) begin
		factor_eval_t e;
		if (arst_n && done) begin
			if (pending_evals.size() == 0) begin
				report_mismatch("done", 63'd1, 63'd0);
			end else begin
				e = pending_evals.pop_front();
				if (predicted_range !== e.pred)
					report_mismatch("predicted_range", 63'(predicted_range), 63'(e.pred));
				if (residual !== e.res)
					report_mismatch("residual", 63'(residual), 63'(e.res));
				if (chi_square !== e.chi)
					report_mismatch("chi_square", chi_square, e.chi);
				if (grad_x !== e.gx)
					report_mismatch("grad_x", 63'(grad_x), 63'(e.gx));
				if (grad_y !== e.gy)
					report_mismatch("grad_y", 63'(grad_y), 63'(e.gy));
				if (grad_z !== e.gz)
					report_mismatch("grad_z", 63'(grad_z), 63'(e.gz));
				if (zero_distance !== e.zero)
					report_mismatch("zero_distance", 63'(zero_distance), 63'(e.zero));
				if (saturated !== e.sat)
					report_mismatch("saturated", 63'(saturated), 63'(e.sat));
			end
		end
	end

	// watchdog: stops a run that makes no progress
	always @(posedge clk) begin
		if ((start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_MAX) begin
			$display("simulation failed");
			$finish;
		end
	end

	// drive one factor beat; start stays high unless a random gap drops it, so the next beat can follow
	task automatic send_factor(factor_t f);
		robot_x <= f.rx;
		robot_y <= f.ry;
		robot_z <= f.rz;
		beacon_x <= f.bx;
		beacon_y <= f.by;
		beacon_z <= f.bz;
		range_bias <= f.bias;
		measured_range <= f.meas;
		weight <= f.w;
		start <= 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		pending_evals.push_back(eval_range_factor(f));
		// random sender gap after about 30 beats in 100
		if (gaps_on && $urandom_range(99) < 30) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 2))
				@(posedge clk);
		end
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		@(posedge clk);
		while (pending_evals.size() != 0)
			@(posedge clk);
	endtask

	function automatic factor_t make_factor(int rx, int ry, int rz, int bx, int by,
			int bz, int bias, int meas, logic [30:0] w);
		factor_t f;
		f.rx = rx; f.ry = ry; f.rz = rz;
		f.bx = bx; f.by = by; f.bz = bz;
		f.bias = bias;
		f.meas = meas;
		f.w = w;
		return f;
	endfunction

	// nearby geometry with random content; sometimes coincident, sometimes full-range noise
	function automatic factor_t random_factor();
		factor_t f;
		int spread;
		f = factor_t'(FACTOR_W'({$urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom, $urandom, $urandom}));
		case ($urandom_range(9))
			0, 1: ;  // full-range noise
			2: begin
				f.bx = f.rx;
				f.by = f.ry;
				f.bz = f.rz;
			end
			default: begin
				spread = 1 << $urandom_range(4, 26);
				f.bx = f.rx + $signed($urandom_range(0, 2 * spread)) - spread;
				f.by = f.ry + $signed($urandom_range(0, 2 * spread)) - spread;
				f.bz = f.rz + $signed($urandom_range(0, 2 * spread)) - spread;
				f.bias = $signed($urandom_range(0, 2 * spread)) - spread;
				f.meas = $signed($urandom_range(0, 4 * spread)) - spread;
				f.w = 31'($urandom_range(0, 1 << $urandom_range(0, 30)));
			end
		endcase
		return f;
	endfunction

	// corners, coincident points, axis-only offsets, clipping
	task automatic test_directed();
		int mx, mn;
		mx = 32'h7fffffff;
		mn = 32'h80000000;
		send_factor(make_factor(0, 0, 0, 0, 0, 0, 0, 0, 0));
		send_factor(make_factor(5, -7, 9, 5, -7, 9, 32'h00030000, 32'h00010000, 31'h10000));
		send_factor(make_factor(mx, mx, mx, mx, mx, mx, mn, mx, '1));
		send_factor(make_factor(mn, mn, mn, mn, mn, mn, mx, mn, '1));
		send_factor(make_factor(mx, mx, mx, mn, mn, mn, 0, 0, 31'h10000));
		send_factor(make_factor(mn, mn, mn, mx, mx, mx, mn, mx, '1));
		send_factor(make_factor(mx, 0, 0, mn, 0, 0, 0, mx, 31'h1));
		send_factor(make_factor(mn, 0, 0, mx, 0, 0, mx, mn, '1));
		send_factor(make_factor(0, 32'h00010000, 0, 0, 0, 0, 0, 32'h00010000, 31'h10000));
		send_factor(make_factor(0, 0, -32'h00020000, 0, 0, 0, 0, 0, 31'h10000));
		send_factor(make_factor(32'h00030000, 32'h00040000, 0, 0, 0, 0,
			-32'h00010000, 32'h00050000, 31'h8000));
		send_factor(make_factor(1, 1, 1, 0, 0, 0, 0, 0, '1));
		send_factor(make_factor(-1, 0, 0, 0, 0, 0, 0, 0, 0));
		send_factor(make_factor(0, 0, 0, 1, 1, 0, mx, mx, '1));
		send_factor(make_factor(100, 200, 300, -100, -200, -300, mn, mx, 31'h40000000));
		send_factor(make_factor(0, mx, 0, 0, mn, 0, mx, 0, 0));
		send_factor(make_factor(0, 0, mx, 0, 0, mn, mn, mn, 31'h10000));
		send_factor(make_factor(32'h01000000, 0, 0, 0, 0, 0, 0, 0, '1));
		send_factor(make_factor(32'hcafe0000, 32'h1234abcd, 32'h7654fedc,
			32'h0badf00d, 32'hfeedbeef, 32'h55aa55aa, 32'haa55aa55, 32'h33333333, '1));
	endtask

	task automatic test_random_gaps(int n);
		repeat (n)
			send_factor(random_factor());
	endtask

	// long back-to-back stretch, start never drops
	task automatic test_back_to_back(int n);
		gaps_on = 1'b0;
		repeat (n)
			send_factor(random_factor());
		gaps_on = 1'b1;
	endtask

	// the sender holds off until the pipe is empty, then resumes
	task automatic test_drain_resume(int n);
		wait_drained();
		repeat (n)
			send_factor(random_factor());
	endtask

	initial begin
		repeat (3)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_gaps(800);
		test_back_to_back(500);
		test_drain_resume(150);
		test_random_gaps(500);
		wait_drained();
		repeat (LATENCY + 20)
			@(posedge clk);
		if (mismatches == 0 && pending_evals.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ===== range_factor_residual_eval.f =====
design/rfre_pkg.sv
design/rfre_front.sv
design/rfre_sqrt.sv
design/rfre_chi.sv
design/rfre_div.sv
design/range_factor_residual_eval.sv
test/tb_top.sv
